// ===== src/lgt_pkg.sv =====
`default_nettype none
package lgt_pkg;

    // fixed field widths
    localparam int ROW_W  = 64;
    localparam int COL_W  = 6;
    localparam int IDX_W  = 10;
    localparam int GW_W   = 7;
    localparam int GH_W   = 11;

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 1024;

    // register reset values
    localparam logic [GW_W-1:0] GW_RESET = GW_W'(64);
    localparam logic [GH_W-1:0] GH_RESET = GH_W'(64);

    // smallest grid side
    localparam int MIN_SIDE = 3;

    // configuration register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // APB port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;
    localparam int QCW    = 3;

endpackage
`default_nettype wire

// ===== src/life_generation_torus_unit.sv =====
`default_nettype none
// One Life generation (B3/S23) on a toroidal grid, streamed row by row.
// Input channel s_*: one old-generation row word per item, rows 0 to height-1
// in order, bit j is column j. Result channel m_*: one new-generation row word
// with its row index; generation_done marks row 0, the last of a generation.
// Rows 0 and 1 give no result, rows 2 to height-2 give the new row before them,
// and the last row gives the new rows height-2, height-1 and 0.
// Results are registered: the row word that completes a result writes it into
// the result queue, from which it is offered. Throughput: one row word per
// cycle; the last row of a generation pushes three results into a four-entry
// result queue, which drains one word per cycle, so the block accepts a word
// whenever the queue has room for every result that word causes.
// When the receiver stalls, the queue fills and s_ready drops once the next
// word's results no longer fit; nothing is lost or reordered.
// Configuration: APB registers grid_width at 0x0 and grid_height at 0x4, pready
// always high. Change them only between words.
// Reset (aresetn low, synchronous): row counter and queue are emptied and the
// registers go to width 64 and height 64.
module life_generation_torus_unit
    import lgt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [ROW_W-1:0]   s_row_cells,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [ROW_W-1:0]   m_new_row_cells,
    output logic      [IDX_W-1:0]   m_row_index,
    output logic                    m_generation_done
);

    localparam int CW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int HCW = (HW > GH_W) ? HW : GH_W;

    logic [GW_W-1:0] grid_width_reg;
    logic [GH_W-1:0] grid_height_reg;

    logic [ROW_W-1:0] first_row_reg;
    logic [ROW_W-1:0] second_row_reg;
    logic [ROW_W-1:0] older_row_reg;
    logic [ROW_W-1:0] newer_row_reg;
    logic [CW-1:0]    rows_reg;
    logic [CW-1:0]    rows_next;

    logic [ROW_W-1:0] q_cells_reg [QDEPTH];
    logic [IDX_W-1:0] q_index_reg [QDEPTH];
    logic             q_done_reg  [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;

    logic [GW_W-1:0]  width_used;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] col_mask;
    logic [HCW-1:0]   height_used;
    logic             last_row;
    logic [1:0]       n_push;
    logic             s_fire;
    logic             m_fire;
    logic [ROW_W-1:0] row_in;

    logic [ROW_W-1:0] res_cells [QDEPTH];
    logic [IDX_W-1:0] res_index [QDEPTH];
    logic             res_done  [QDEPTH];

    logic [CW+IDX_W-1:0] idx_prev_wide;
    logic [CW+IDX_W-1:0] idx_cur_wide;

    // new middle row from three neighbor rows, wrapping at the used width
    function automatic logic [ROW_W-1:0] life_row(
        input logic [ROW_W-1:0] above,
        input logic [ROW_W-1:0] mid,
        input logic [ROW_W-1:0] below,
        input logic [ROW_W-1:0] mask,
        input logic [COL_W-1:0] lc
    );
        logic [ROW_W-1:0] a, m, b;
        logic [ROW_W-1:0] al, ar, ml, mr, bl, br;
        logic [ROW_W-1:0] res;
        logic [3:0]       n;
        a = above & mask;
        m = mid & mask;
        b = below & mask;
        al = {a[ROW_W-2:0], a[lc]};
        ml = {m[ROW_W-2:0], m[lc]};
        bl = {b[ROW_W-2:0], b[lc]};
        ar = {1'b0, a[ROW_W-1:1]};
        mr = {1'b0, m[ROW_W-1:1]};
        br = {1'b0, b[ROW_W-1:1]};
        for (int j = 0; j < ROW_W; j++) begin
            if (COL_W'(j) == lc) begin
                ar[j] = a[0];
                mr[j] = m[0];
                br[j] = b[0];
            end
        end
        res = '0;
        for (int j = 0; j < ROW_W; j++) begin
            n = 4'(al[j]) + 4'(a[j]) + 4'(ar[j]) + 4'(ml[j]) + 4'(mr[j])
              + 4'(bl[j]) + 4'(b[j]) + 4'(br[j]);
            res[j] = mask[j] & ((n == 4'd3) | ((n == 4'd2) & m[j]));
        end
        return res;
    endfunction

    // clamp registers to their usable ranges
    always_comb begin
        if (grid_width_reg < GW_W'(MIN_SIDE)) begin
            width_used = GW_W'(MIN_SIDE);
        end else if (grid_width_reg > GW_W'(MAX_WIDTH)) begin
            width_used = GW_W'(MAX_WIDTH);
        end else begin
            width_used = grid_width_reg;
        end
        if (HCW'(grid_height_reg) < HCW'(MIN_SIDE)) begin
            height_used = HCW'(MIN_SIDE);
        end else if (HCW'(grid_height_reg) > HCW'(MAX_HEIGHT)) begin
            height_used = HCW'(MAX_HEIGHT);
        end else begin
            height_used = HCW'(grid_height_reg);
        end
    end

    assign last_col = COL_W'(width_used - GW_W'(1));

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            col_mask[j] = (GW_W'(j) < width_used);
        end
    end

    assign row_in   = s_row_cells & col_mask;
    assign last_row = (rows_reg >= CW'(2)) && (HCW'(rows_reg) >= height_used - HCW'(1));

    always_comb begin
        if (rows_reg < CW'(2)) begin
            n_push = 2'd0;
        end else if (last_row) begin
            n_push = 2'd3;
        end else begin
            n_push = 2'd1;
        end
    end

    assign s_ready = (count_reg + QCW'(n_push)) <= QCW'(QDEPTH);
    assign s_fire  = s_valid & s_ready;
    assign m_valid = (count_reg != '0);
    assign m_fire  = m_valid & m_ready;

    assign idx_prev_wide = {{IDX_W{1'b0}}, rows_reg - CW'(1)};
    assign idx_cur_wide  = {{IDX_W{1'b0}}, rows_reg};

    always_comb begin
        res_cells[0] = life_row(older_row_reg, newer_row_reg, row_in, col_mask, last_col);
        res_index[0] = idx_prev_wide[IDX_W-1:0];
        res_done[0]  = 1'b0;
        res_cells[1] = life_row(newer_row_reg, row_in, first_row_reg, col_mask, last_col);
        res_index[1] = idx_cur_wide[IDX_W-1:0];
        res_done[1]  = 1'b0;
        res_cells[2] = life_row(row_in, first_row_reg, second_row_reg, col_mask, last_col);
        res_index[2] = '0;
        res_done[2]  = 1'b1;
        res_cells[3] = '0;
        res_index[3] = '0;
        res_done[3]  = 1'b0;
    end

    assign rows_next  = last_row ? '0 : CW'(rows_reg + CW'(1));
    assign count_next = count_reg + (s_fire ? QCW'(n_push) : QCW'(0)) - QCW'(m_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GW_RESET;
            grid_height_reg <= GH_RESET;
            rows_reg        <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[2])
                    REG_GRID_WIDTH:  grid_width_reg  <= pwdata[GW_W-1:0];
                    REG_GRID_HEIGHT: grid_height_reg <= pwdata[GH_W-1:0];
                    default: ;
                endcase
            end
            if (s_fire) begin
                rows_reg   <= rows_next;
                wr_ptr_reg <= wr_ptr_reg + QPW'(n_push);
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            end
            count_reg <= count_next;
        end
    end

    // row history and result queue payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (rows_reg == CW'(0)) begin
                first_row_reg <= row_in;
            end
            if (rows_reg == CW'(1)) begin
                second_row_reg <= row_in;
            end
            older_row_reg <= newer_row_reg;
            newer_row_reg <= row_in;
            for (int e = 0; e < QDEPTH; e++) begin
                if (QPW'(QPW'(e) - wr_ptr_reg) < n_push) begin
                    q_cells_reg[e] <= res_cells[QPW'(QPW'(e) - wr_ptr_reg)];
                    q_index_reg[e] <= res_index[QPW'(QPW'(e) - wr_ptr_reg)];
                    q_done_reg[e]  <= res_done[QPW'(QPW'(e) - wr_ptr_reg)];
                end
            end
        end
    end

    assign m_new_row_cells   = q_cells_reg[rd_ptr_reg];
    assign m_row_index       = q_index_reg[rd_ptr_reg];
    assign m_generation_done = q_done_reg[rd_ptr_reg];

    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== tb/life_torus_checker.sv =====
`timescale 1ns / 100ps

module life_torus_checker
    import lgt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    input  wire logic               pready,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [ROW_W-1:0]   s_row_cells,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [ROW_W-1:0]   m_new_row_cells,
    input  wire logic [IDX_W-1:0]   m_row_index,
    input  wire logic               m_generation_done,
    output int                      mismatches,
    output int                      rows_pending,
    output int                      rows_checked,
    output int                      generations_closed
);

    typedef struct packed {
        logic [ROW_W-1:0] cells;
        logic [IDX_W-1:0] index;
        logic             done;
    } life_row_t;

    life_row_t        expected_rows[$];
    logic [GW_W-1:0]  grid_width;
    logic [GH_W-1:0]  grid_height;
    logic [ROW_W-1:0] row_zero;
    logic [ROW_W-1:0] row_one;
    logic [ROW_W-1:0] row_above;
    logic [ROW_W-1:0] row_mid;
    logic [IDX_W-1:0] next_index;

    function automatic int width_in_use();
        int w;
        w = grid_width;
        if (w < MIN_SIDE) w = MIN_SIDE;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        return w;
    endfunction

    function automatic int height_in_use();
        int h;
        h = grid_height;
        if (h < MIN_SIDE) h = MIN_SIDE;
        if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
        return h;
    endfunction

    function automatic logic [ROW_W-1:0] live_mask(input int w);
        return (w >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << w) - 1);
    endfunction

    // b3/s23 on the middle row, columns wrap at the width in use
    function automatic logic [ROW_W-1:0] evolve_row(input logic [ROW_W-1:0] above,
                                                    input logic [ROW_W-1:0] mid,
                                                    input logic [ROW_W-1:0] below,
                                                    input int w);
        logic [ROW_W-1:0] keep;
        logic [ROW_W-1:0] fresh;
        int left;
        int right;
        int count;
        keep  = live_mask(w);
        above = above & keep;
        mid   = mid & keep;
        below = below & keep;
        fresh = '0;
        for (int j = 0; j < w; j++) begin
            left  = (j == 0) ? w - 1 : j - 1;
            right = (j == w - 1) ? 0 : j + 1;
            count = above[left] + above[j] + above[right] + mid[left] + mid[right]
                  + below[left] + below[j] + below[right];
            if (count == 3) fresh[j] = 1'b1;
            else if (count == 2) fresh[j] = mid[j];
        end
        return fresh;
    endfunction

    function automatic void push_expected(input logic [ROW_W-1:0] cells,
                                          input logic [IDX_W-1:0] index,
                                          input logic done);
        life_row_t item;
        item.cells = cells;
        item.index = index;
        item.done  = done;
        expected_rows.push_back(item);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        life_row_t        want;
        logic [ROW_W-1:0] row;
        int               w;
        int               h;
        if (!aresetn) begin
            grid_width  = GW_RESET;
            grid_height = GH_RESET;
            row_zero    = '0;
            row_one     = '0;
            row_above   = '0;
            row_mid     = '0;
            next_index  = '0;
            expected_rows.delete();
        end else begin
            // results first: a word taken at this edge cannot have produced one yet
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    report_mismatch($sformatf("row %0d word with nothing expected",
                                              m_row_index));
                end else begin
                    want = expected_rows.pop_front();
                    if (m_new_row_cells !== want.cells)
                        report_mismatch($sformatf("row %0d cells %h, expected %h",
                                                  want.index, m_new_row_cells, want.cells));
                    if (m_row_index !== want.index)
                        report_mismatch($sformatf("row index %0d, expected %0d",
                                                  m_row_index, want.index));
                    if (m_generation_done !== want.done)
                        report_mismatch($sformatf("row %0d generation_done %b, expected %b",
                                                  want.index, m_generation_done, want.done));
                    rows_checked++;
                    if (want.done) generations_closed++;
                end
            end

            if (s_valid && s_ready) begin
                w   = width_in_use();
                h   = height_in_use();
                row = s_row_cells & live_mask(w);
                if (next_index == 0) begin
                    row_zero = row;
                end else if (next_index == 1) begin
                    row_one = row;
                end else begin
                    push_expected(evolve_row(row_above, row_mid, row, w),
                                  IDX_W'(next_index - 1'b1), 1'b0);
                    if (next_index >= h - 1) begin
                        push_expected(evolve_row(row_mid, row, row_zero, w), next_index, 1'b0);
                        push_expected(evolve_row(row, row_zero, row_one, w), '0, 1'b1);
                    end
                end
                row_above = row_mid;
                row_mid   = row;
                if (next_index >= 2 && next_index >= h - 1) next_index = '0;
                else next_index = next_index + 1'b1;
            end

            // a register written at this edge applies from the next word on
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_GRID_WIDTH, 2'b00}) grid_width = pwdata[GW_W-1:0];
                else if (paddr == {REG_GRID_HEIGHT, 2'b00}) grid_height = pwdata[GH_W-1:0];
            end
        end
        rows_pending = expected_rows.size();
    end

endmodule

// ===== tb/life_generation_torus_unit_tb.sv =====
`timescale 1ns / 100ps

module life_generation_torus_unit_tb;
    import lgt_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ROWS    = 400;
    localparam int CALM_FROM      = 340;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [PADDR_W-1:0] WIDTH_ADDR  = {REG_GRID_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = {REG_GRID_HEIGHT, 2'b00};

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [ROW_W-1:0]   s_row_cells = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [ROW_W-1:0]   m_new_row_cells;
    logic [IDX_W-1:0]   m_row_index;
    logic               m_generation_done;

    int mismatches;
    int rows_pending;
    int rows_checked;
    int generations_closed;

    bit quiet       = 1'b0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int rows_sent   = 0;
    int settings    = 0;
    int row_pos     = 0;
    int height_used = GH_RESET;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    life_generation_torus_unit uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_row_cells       (s_row_cells),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_new_row_cells   (m_new_row_cells),
        .m_row_index       (m_row_index),
        .m_generation_done (m_generation_done)
    );

    life_torus_checker life_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_row_cells        (s_row_cells),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_new_row_cells    (m_new_row_cells),
        .m_row_index        (m_row_index),
        .m_generation_done  (m_generation_done),
        .mismatches         (mismatches),
        .rows_pending       (rows_pending),
        .rows_checked       (rows_checked),
        .generations_closed (generations_closed)
    );

    // receiver stalls come in bursts, started at random unless quiet
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [ROW_W-1:0] random_cells();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return a & b & {$urandom, $urandom};
            1: return a & b;
            2: return a | b;
            3: return ($urandom_range(0, 1) != 0) ? '0 : {ROW_W{1'b1}};
            default: return a;
        endcase
    endfunction

    task automatic send_row(input logic [ROW_W-1:0] cells);
        bit took;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_cells <= cells;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        rows_sent++;
        if (row_pos >= 2 && row_pos >= height_used - 1) row_pos = 0;
        else row_pos++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (rows_pending != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            done = pready;
            @(posedge aclk);
        end while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input bit set_w, input logic [PDATA_W-1:0] w_data,
                             input bit set_h, input logic [PDATA_W-1:0] h_data);
        int h;
        wait_drained();
        // rows 0 and 1 leave nothing to wait for, so let the block settle before the writes
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (set_w) write_reg(WIDTH_ADDR, w_data);
        if (set_h) begin
            write_reg(HEIGHT_ADDR, h_data);
            h = h_data[GH_W-1:0];
            if (h < MIN_SIDE) h = MIN_SIDE;
            if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
            height_used = h;
        end
        settings++;
    endtask

    initial begin
        int                 rand_rows;
        int                 count;
        int                 phase;
        logic [PDATA_W-1:0] wv;
        logic [PDATA_W-1:0] hv;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest grid, width and height below range
        configure(1'b1, 0, 1'b1, 0);
        send_row({ROW_W{1'b1}});
        send_row('0);
        send_row(64'h5);

        // width above range, full-width stripes
        configure(1'b1, 127, 1'b1, 4);
        send_row({ROW_W{1'b1}});
        send_row('0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA);
        send_row(64'h5555_5555_5555_5555);

        // bits above the width are ignored
        configure(1'b1, 5, 1'b1, 3);
        send_row({ROW_W{1'b1}});
        send_row(64'hFFFF_FFFF_FFFF_FFE0);
        send_row(64'h11);

        // registers changed in the middle of a generation
        configure(1'b1, ROW_W, 1'b1, 5);
        send_row(64'h1);
        send_row(64'h8000_0000_0000_0001);
        configure(1'b1, 10, 1'b1, 3);
        send_row(64'h0000_0000_0000_FFFF);

        // wrap between column 63 and column 0
        configure(1'b1, ROW_W, 1'b1, 3);
        send_row(64'h8000_0000_0000_0000);
        send_row(64'hC000_0000_0000_0001);
        send_row(64'h1);

        // height above range, left unfinished
        configure(1'b0, 0, 1'b1, 2047);
        send_row(random_cells());
        send_row(random_cells());
        send_row(random_cells());

        rand_rows = 0;
        phase     = 0;
        while (rand_rows < RANDOM_ROWS) begin
            wv = $urandom;
            case ($urandom_range(0, 9))
                0: wv[GW_W-1:0] = MIN_SIDE;
                1: wv[GW_W-1:0] = ROW_W;
                2: wv[GW_W-1:0] = $urandom_range(0, MIN_SIDE - 1);
                3: wv[GW_W-1:0] = $urandom_range(DEF_MAX_WIDTH + 1, 127);
                default: wv[GW_W-1:0] = $urandom_range(MIN_SIDE, ROW_W);
            endcase
            if ($urandom_range(0, 1) != 0) wv[PDATA_W-1:GW_W] = '0;
            hv = $urandom;
            case ($urandom_range(0, 9))
                0: hv[GH_W-1:0] = MIN_SIDE;
                1: hv[GH_W-1:0] = $urandom_range(0, MIN_SIDE - 1);
                2: hv[GH_W-1:0] = GH_RESET;
                3: hv[GH_W-1:0] = $urandom_range(13, 40);
                default: hv[GH_W-1:0] = $urandom_range(MIN_SIDE, 12);
            endcase
            if ($urandom_range(0, 1) != 0) hv[PDATA_W-1:GH_W] = '0;
            configure(phase == 0 || $urandom_range(0, 3) != 0, wv,
                      phase == 0 || $urandom_range(0, 3) != 0, hv);
            quiet = (rand_rows >= CALM_FROM) || ($urandom_range(0, 3) == 0);

            // mostly whole generations, sometimes cut short
            if ($urandom_range(0, 4) == 0) begin
                count = $urandom_range(1, height_used);
            end else begin
                count = height_used - row_pos + $urandom_range(0, 1) * height_used;
                if (count < 1) count = 1;
            end
            for (int i = 0; i < count; i++) begin
                send_row(random_cells());
                rand_rows++;
                if (rand_rows >= CALM_FROM) quiet = 1'b1;
                if (!quiet && $urandom_range(0, 63) == 0) wait_drained();
            end
            phase++;
        end

        quiet = 1'b1;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);

        $display("sent %0d row words under %0d register settings, heights up to %0d",
                 rows_sent, settings, DEF_MAX_HEIGHT);
        $display("compared %0d result rows, %0d generations closed, %0d mismatches",
                 rows_checked, generations_closed, mismatches);
        if (mismatches == 0 && rows_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
